// ===== design/fdwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry filter package
// Shared constants, command codes and verdict codes for the 8.3 name filter.
// ----------------------------------------------------------------------------
package fdwf_pkg;

    localparam int unsigned NAME_LEN = 11;
    localparam int unsigned BASE_LEN = 8;
    localparam int unsigned EXT_LEN  = 3;

    typedef logic [7:0] name_byte_t;
    typedef logic [3:0] fill_pos_t;

    localparam name_byte_t CH_WILD    = 8'h3F;
    localparam name_byte_t CH_DOT     = 8'h2E;
    localparam name_byte_t CH_STAR    = 8'h2A;
    localparam name_byte_t CH_DELETED = 8'hE5;
    localparam name_byte_t CH_SPACE   = 8'h20;
    localparam name_byte_t CH_NUL     = 8'h00;

    localparam fill_pos_t FILL_EXT  = 4'd8;
    localparam fill_pos_t FILL_FULL = 4'd11;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_CHAR = 2'd1,
        CMD_CLASSIFY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        VERDICT_MATCH   = 3'd0,
        VERDICT_NOMATCH = 3'd1,
        VERDICT_DOT     = 3'd2,
        VERDICT_DELETED = 3'd3,
        VERDICT_END     = 3'd4,
        VERDICT_AFTER   = 3'd5
    } verdict_t;

    // Name bytes of the "." and ".." directory entries.
    function automatic name_byte_t one_dot_byte(input int unsigned idx);
        return (idx == 0) ? CH_DOT : CH_SPACE;
    endfunction

    function automatic name_byte_t two_dots_byte(input int unsigned idx);
        return (idx < 2) ? CH_DOT : CH_SPACE;
    endfunction

endpackage

// ===== design/fdwf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry filter channels
// Valid/ready channels for filter commands and for classification results.
// ----------------------------------------------------------------------------
interface fdwf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  pattern_char;
    logic [63:0] entry_name;
    logic [23:0] entry_ext;

    modport source (output valid, output cmd, output pattern_char, output entry_name,
                    output entry_ext, input ready);
    modport sink   (input valid, input cmd, input pattern_char, input entry_name,
                    input entry_ext, output ready);
endinterface

interface fdwf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       free_slot;

    modport source (output valid, output verdict, output free_slot, input ready);
    modport sink   (input valid, input verdict, input free_slot, output ready);
endinterface

// ===== design/fat_dir_entry_wildcard_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry wildcard filter
// Builds an 8.3 search pattern and classifies streamed directory entry names.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                   Transfers
//  item      in         cmd, pattern_char, entry_name, entry_ext  every command
//  result    out        verdict, free_slot                        classify only
//
//  A classify command shows its result on the next cycle from the result
//  register. One command per cycle is sustained while no result is stalled,
//  set by the 11-byte parallel compares in front of the result register.
//  item.ready drops only while a result is held and result.ready is low.
//  Reset sets the pattern to all spaces, the fill position to zero and clears
//  the end-of-directory flag and the result valid flag.
// ----------------------------------------------------------------------------
module fat_dir_entry_wildcard_filter
(
    input  logic          clk,
    input  logic          rst_n,
    fdwf_cmd_if.sink      item,
    fdwf_result_if.source result
);
    import fdwf_pkg::*;

    name_byte_t pattern_reg  [NAME_LEN];
    name_byte_t pattern_next [NAME_LEN];
    fill_pos_t  fill_reg;
    fill_pos_t  fill_next;
    logic       end_seen_reg;
    logic       end_seen_next;

    logic       result_valid_reg;
    logic       result_valid_next;
    verdict_t   verdict_reg;
    verdict_t   verdict_next;
    logic       free_slot_reg;
    logic       free_slot_next;

    name_byte_t entry       [NAME_LEN];
    logic       accept;
    logic       is_one_dot;
    logic       is_two_dots;
    logic       pattern_hit;

    assign item.ready       = !result_valid_reg || result.ready;
    assign accept           = item.valid && item.ready;
    assign result.valid     = result_valid_reg;
    assign result.verdict   = verdict_reg;
    assign result.free_slot = free_slot_reg;

    always_comb
    begin
        for (int i = 0; i < BASE_LEN; i++)
        begin
            entry[i] = item.entry_name[8*i +: 8];
        end
        for (int i = 0; i < EXT_LEN; i++)
        begin
            entry[BASE_LEN + i] = item.entry_ext[8*i +: 8];
        end
    end

    // A '?' on either side matches any byte.
    always_comb
    begin
        is_one_dot  = 1'b1;
        is_two_dots = 1'b1;
        pattern_hit = 1'b1;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            if (entry[i] != CH_WILD && entry[i] != one_dot_byte(i))
            begin
                is_one_dot = 1'b0;
            end
            if (entry[i] != CH_WILD && entry[i] != two_dots_byte(i))
            begin
                is_two_dots = 1'b0;
            end
            if (entry[i] != CH_WILD && pattern_reg[i] != CH_WILD &&
                entry[i] != pattern_reg[i])
            begin
                pattern_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        pattern_next      = pattern_reg;
        fill_next         = fill_reg;
        end_seen_next     = end_seen_reg;
        result_valid_next = result_valid_reg && !result.ready;
        verdict_next      = verdict_reg;
        free_slot_next    = free_slot_reg;

        if (accept)
        begin
            unique case (item.cmd)
                CMD_CLEAR:
                begin
                    for (int i = 0; i < NAME_LEN; i++)
                    begin
                        pattern_next[i] = CH_SPACE;
                    end
                    fill_next     = '0;
                    end_seen_next = 1'b0;
                end
                CMD_ADD_CHAR:
                begin
                    priority if (item.pattern_char == CH_DOT)
                    begin
                        for (int i = BASE_LEN; i < NAME_LEN; i++)
                        begin
                            pattern_next[i] = CH_SPACE;
                        end
                        fill_next = FILL_EXT;
                    end
                    else if (item.pattern_char == CH_STAR)
                    begin
                        for (int i = 0; i < NAME_LEN; i++)
                        begin
                            if (4'(i) >= fill_reg)
                            begin
                                pattern_next[i] = CH_WILD;
                            end
                        end
                        fill_next = FILL_FULL;
                    end
                    else if (fill_reg < FILL_FULL)
                    begin
                        for (int i = 0; i < NAME_LEN; i++)
                        begin
                            if (4'(i) == fill_reg)
                            begin
                                pattern_next[i] = item.pattern_char;
                            end
                        end
                        fill_next = fill_reg + 4'd1;
                    end
                    else
                    begin
                        fill_next = fill_reg;
                    end
                end
                CMD_CLASSIFY:
                begin
                    result_valid_next = 1'b1;
                    free_slot_next    = 1'b0;
                    priority if (end_seen_reg)
                    begin
                        verdict_next = VERDICT_AFTER;
                    end
                    else if (entry[0] == CH_NUL)
                    begin
                        verdict_next   = VERDICT_END;
                        free_slot_next = 1'b1;
                        end_seen_next  = 1'b1;
                    end
                    else if (is_one_dot || is_two_dots)
                    begin
                        verdict_next = VERDICT_DOT;
                    end
                    else if (entry[0] == CH_DELETED)
                    begin
                        verdict_next   = VERDICT_DELETED;
                        free_slot_next = 1'b1;
                    end
                    else
                    begin
                        verdict_next = pattern_hit ? VERDICT_MATCH : VERDICT_NOMATCH;
                    end
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAME_LEN; i++)
            begin
                pattern_reg[i] <= CH_SPACE;
            end
            fill_reg         <= '0;
            end_seen_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg      <= pattern_next;
            fill_reg         <= fill_next;
            end_seen_reg     <= end_seen_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg   <= verdict_next;
        free_slot_reg <= free_slot_next;
    end

endmodule

// ===== design/fdwf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry filter checker
// Port-level properties of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fdwf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic [1:0] item_cmd,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] result_verdict,
    input logic       result_free_slot
);
    import fdwf_pkg::*;

    // A held result keeps its payload until the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_verdict) && $stable(result_free_slot))
        else $error("result payload changed while stalled");

    // Every accepted classify command produces a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_cmd == CMD_CLASSIFY |=> result_valid)
        else $error("classify command gave no result");

    // A stalled result blocks new commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("command accepted while result stalled");

    // Only the end marker and deleted entries report a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result_free_slot == (result_verdict == VERDICT_END ||
                                  result_verdict == VERDICT_DELETED)))
        else $error("free_slot inconsistent with verdict");

    // Verdict codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_verdict <= VERDICT_AFTER)
        else $error("undefined verdict code");

endmodule

bind fat_dir_entry_wildcard_filter fdwf_checker u_fdwf_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_cmd         (item.cmd),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_verdict   (result.verdict),
    .result_free_slot (result.free_slot)
);
